// ----- design/qse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the queue and stack exchange engine.
package qse_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int STACK_DEPTH_DEF = 4;
	localparam int SWAP_COUNT_DEF  = 3;

	localparam int ACTION_W = 3;
	localparam int KIND_W   = 2;
	localparam int ID_W     = 32;
	localparam int STATUS_W = 3;
	localparam int QFILL_W  = 4;
	localparam int SFILL_W  = 3;
	localparam int IDX_W    = 2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
	} item_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND     = 3'd0,
		ACT_PLAY       = 3'd1,
		ACT_RESERVE    = 3'd2,
		ACT_USE_TOP    = 3'd3,
		ACT_SWAP_ONE   = 3'd4,
		ACT_SWAP_THREE = 3'd5
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK          = 3'd0,
		STS_QUEUE_EMPTY = 3'd1,
		STS_QUEUE_FULL  = 3'd2,
		STS_STACK_FULL  = 3'd3,
		STS_STACK_EMPTY = 3'd4,
		STS_TOO_FEW     = 3'd5
	} sts_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWAP,
		S_LAST,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_APPEND,
		DP_PLAY,
		DP_RESERVE,
		DP_POP,
		DP_SWAP
	} dp_op_t;

	typedef struct packed {
		logic             load;
		logic             publish;
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
		sts_code_t        code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic q_empty;
		logic q_full;
		logic q_few;
		logic s_empty;
		logic s_full;
		logic s_few;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- design/qse_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: decodes the action and sequences the datapath.
module qse_ctrl #(
	parameter int SWAP_COUNT = qse_pkg::SWAP_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qse_pkg::ACTION_W-1:0]  action,
	input  qse_pkg::dp_stat_t             sts,
	output qse_pkg::ctrl_cmd_t            cmd
);
	import qse_pkg::*;

	state_t           state_q, state_d;
	dp_op_t           op_q, op_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= DP_NONE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		idx_d       = idx_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.publish = 1'b0;
		cmd.op      = DP_NONE;
		cmd.idx     = '0;
		cmd.code    = STS_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LAST;
					op_d     = DP_NONE;
					idx_d    = IDX_W'(1);
					case (action)
						ACT_APPEND: begin
							if (sts.q_full) cmd.code = STS_QUEUE_FULL;
							else op_d = DP_APPEND;
						end
						ACT_PLAY: begin
							if (sts.q_empty) cmd.code = STS_QUEUE_EMPTY;
							else op_d = DP_PLAY;
						end
						ACT_RESERVE: begin
							if (sts.s_full) cmd.code = STS_STACK_FULL;
							else if (sts.q_empty) cmd.code = STS_QUEUE_EMPTY;
							else op_d = DP_RESERVE;
						end
						ACT_USE_TOP: begin
							if (sts.s_empty) cmd.code = STS_STACK_EMPTY;
							else op_d = DP_POP;
						end
						ACT_SWAP_ONE: begin
							if (sts.q_empty || sts.s_empty) cmd.code = STS_TOO_FEW;
							else op_d = DP_SWAP;
						end
						ACT_SWAP_THREE: begin
							if (sts.q_few || sts.s_few) begin
								cmd.code = STS_TOO_FEW;
							end else begin
								op_d = DP_SWAP;
								// first pair is read now; walk the rest one pair a cycle
								if (SWAP_COUNT > 1) state_d = S_SWAP;
							end
						end
						default: begin
							cmd.code = STS_OK;
						end
					endcase
					if (op_d == DP_NONE) state_d = S_FINISH;
				end
			end
			S_SWAP: begin
				// write back the previous pair while reading the next one
				cmd.op  = DP_SWAP;
				cmd.idx = idx_q;
				if (idx_q == IDX_W'(SWAP_COUNT - 1)) begin
					state_d = S_LAST;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_LAST: begin
				cmd.op  = op_q;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				// hold the result until the output register is free
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/qse_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: queue and stack memories, pointers, counts and the output register.
module qse_dpath #(
	parameter int QUEUE_DEPTH = qse_pkg::QUEUE_DEPTH_DEF,
	parameter int STACK_DEPTH = qse_pkg::STACK_DEPTH_DEF,
	parameter int SWAP_COUNT  = qse_pkg::SWAP_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qse_pkg::ctrl_cmd_t            cmd,
	output qse_pkg::dp_stat_t             sts,
	input  logic [qse_pkg::KIND_W-1:0]    new_kind,
	input  logic [qse_pkg::ID_W-1:0]      new_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [qse_pkg::STATUS_W-1:0]  status,
	output logic                          item_valid,
	output logic [qse_pkg::KIND_W-1:0]    item_kind,
	output logic [qse_pkg::ID_W-1:0]      item_id,
	output logic [qse_pkg::QFILL_W-1:0]   queue_fill,
	output logic [qse_pkg::SFILL_W-1:0]   stack_fill
);
	import qse_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);

	item_t q_mem [QUEUE_DEPTH];
	item_t s_mem [STACK_DEPTH];

	logic [QAW-1:0] q_head_q;
	logic [QCW-1:0] q_count_q;
	logic [SCW-1:0] s_count_q;

	item_t          fresh_q;
	sts_code_t      code_q;
	logic           got_valid_q;
	item_t          got_q;

	item_t          q_rdata_s1, s_rdata_s1;
	logic [QAW-1:0] q_raddr_s1;
	logic [SAW-1:0] s_raddr_s1;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_iv_q;
	item_t               out_item_q;
	logic [QFILL_W-1:0]  out_qf_q;
	logic [SFILL_W-1:0]  out_sf_q;

	logic [QCW:0]   q_sum_rd, q_sum_tail;
	logic [QAW-1:0] q_raddr, q_tail, q_head_inc;
	logic [SAW-1:0] s_raddr;
	logic           q_we, s_we;
	logic [QAW-1:0] q_waddr;
	logic [SAW-1:0] s_waddr;
	item_t          q_wdata, s_wdata;

	// read address: head plus pair index, wrapped by one compare and subtract
	always_comb begin
		q_sum_rd   = (QCW+1)'(q_head_q) + (QCW+1)'(cmd.idx);
		q_raddr    = (q_sum_rd >= (QCW+1)'(QUEUE_DEPTH)) ?
			QAW'(q_sum_rd - (QCW+1)'(QUEUE_DEPTH)) : QAW'(q_sum_rd);
		q_sum_tail = (QCW+1)'(q_head_q) + (QCW+1)'(q_count_q);
		q_tail     = (q_sum_tail >= (QCW+1)'(QUEUE_DEPTH)) ?
			QAW'(q_sum_tail - (QCW+1)'(QUEUE_DEPTH)) : QAW'(q_sum_tail);
		q_head_inc = (q_head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + QAW'(1);
		if (s_count_q > SCW'(cmd.idx)) begin
			s_raddr = SAW'(s_count_q - SCW'(cmd.idx) - SCW'(1));
		end else begin
			s_raddr = '0;
		end
	end

	always_comb begin
		q_we    = 1'b0;
		s_we    = 1'b0;
		q_waddr = q_tail;
		s_waddr = SAW'(s_count_q);
		q_wdata = fresh_q;
		s_wdata = q_rdata_s1;
		case (cmd.op)
			DP_APPEND, DP_PLAY: begin
				q_we = 1'b1;
			end
			DP_RESERVE: begin
				q_we = 1'b1;
				s_we = 1'b1;
			end
			DP_SWAP: begin
				q_we    = 1'b1;
				s_we    = 1'b1;
				q_waddr = q_raddr_s1;
				s_waddr = s_raddr_s1;
				q_wdata = s_rdata_s1;
			end
			default: begin
				q_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		q_rdata_s1 <= q_mem[q_raddr];
		q_raddr_s1 <= q_raddr;
		if (q_we) q_mem[q_waddr] <= q_wdata;
	end

	always_ff @(posedge clk) begin
		s_rdata_s1 <= s_mem[s_raddr];
		s_raddr_s1 <= s_raddr;
		if (s_we) s_mem[s_waddr] <= s_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q    <= '0;
			q_count_q   <= '0;
			s_count_q   <= '0;
			got_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				DP_APPEND: begin
					q_count_q <= q_count_q + QCW'(1);
				end
				DP_PLAY: begin
					q_head_q    <= q_head_inc;
					got_valid_q <= 1'b1;
				end
				DP_RESERVE: begin
					q_head_q    <= q_head_inc;
					s_count_q   <= s_count_q + SCW'(1);
					got_valid_q <= 1'b1;
				end
				DP_POP: begin
					s_count_q   <= s_count_q - SCW'(1);
					got_valid_q <= 1'b1;
				end
				default: begin
					got_valid_q <= got_valid_q & ~cmd.load;
				end
			endcase
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fresh_q.kind <= new_kind;
			fresh_q.id   <= new_id;
			code_q       <= cmd.code;
		end
		if (cmd.op == DP_PLAY || cmd.op == DP_RESERVE) got_q <= q_rdata_s1;
		else if (cmd.op == DP_POP) got_q <= s_rdata_s1;
		if (cmd.publish) begin
			out_status_q <= code_q;
			out_iv_q     <= got_valid_q;
			// report zeros when no word was removed
			out_item_q   <= got_valid_q ? got_q : '0;
			out_qf_q     <= QFILL_W'(q_count_q);
			out_sf_q     <= SFILL_W'(s_count_q);
		end
	end

	assign sts.q_empty  = (q_count_q == '0);
	assign sts.q_full   = (q_count_q == QCW'(QUEUE_DEPTH));
	assign sts.q_few    = (q_count_q < QCW'(SWAP_COUNT));
	assign sts.s_empty  = (s_count_q == '0);
	assign sts.s_full   = (s_count_q == SCW'(STACK_DEPTH));
	assign sts.s_few    = (s_count_q < SCW'(SWAP_COUNT));
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign item_valid = out_iv_q;
	assign item_kind  = out_item_q.kind;
	assign item_id    = out_item_q.id;
	assign queue_fill = out_qf_q;
	assign stack_fill = out_sf_q;

endmodule

// ----- design/queue_stack_exchange_engine.sv -----
`timescale 1ns / 1ps
// Top level of the queue and stack exchange engine.
//
// One word on the slave stream carries an action (tuser) and an incoming item
// (tdata); each accepted word yields exactly one result word on the master
// stream: status, removed item, and the queue and stack fills after the step.
// The queue and stack are small memories with one registered read port each,
// so an item is read in the accept cycle and written back in the next cycle.
// After the accepting edge, a rejected action or an unused code goes straight
// to the finish state; append, play, reserve, use-top and swap-one pass the
// last state on the way, and swap-three walks its other pairs in the swap
// state (one pair per cycle) before the last state. The result is published
// from the finish state once the output register is free, and the next word
// is taken as soon as the block is back in its idle state.
// A result waiting in the output register does not block acceptance; only the
// publication of the following result waits for m_tready, and until then no
// further word is taken.
// Reset empties the queue and the stack and drops any pending result; stored
// items are not cleared and need no clearing pass.
module queue_stack_exchange_engine #(
	parameter int QUEUE_DEPTH = qse_pkg::QUEUE_DEPTH_DEF,
	parameter int STACK_DEPTH = qse_pkg::STACK_DEPTH_DEF,
	parameter int SWAP_COUNT  = qse_pkg::SWAP_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // new_kind[1:0], new_id[33:2], zero[39:34]
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // item_kind[1:0], item_id[33:2], queue_fill[37:34],
	                               // stack_fill[40:38], zero[47:41]
	output logic [3:0]  m_tuser    // status[2:0], item_valid[3]
);
	import qse_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  sts;

	logic [STATUS_W-1:0] status;
	logic                item_valid;
	logic [KIND_W-1:0]   item_kind;
	logic [ID_W-1:0]     item_id;
	logic [QFILL_W-1:0]  queue_fill;
	logic [SFILL_W-1:0]  stack_fill;

	qse_ctrl #(
		.SWAP_COUNT(SWAP_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser[ACTION_W-1:0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	qse_dpath #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.STACK_DEPTH(STACK_DEPTH),
		.SWAP_COUNT (SWAP_COUNT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.new_kind   (s_tdata[KIND_W-1:0]),
		.new_id     (s_tdata[KIND_W+ID_W-1:KIND_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.status     (status),
		.item_valid (item_valid),
		.item_kind  (item_kind),
		.item_id    (item_id),
		.queue_fill (queue_fill),
		.stack_fill (stack_fill)
	);

	assign m_tdata = {7'd0, stack_fill, queue_fill, item_id, item_kind};
	assign m_tuser = {item_valid, status};

	// every step leaves the idle state once its word is taken, so a word is never taken back to back
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted in two consecutive cycles");

	// a removed item is reported only by a successful step
	a_item_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == STS_OK))
		else $error("item reported with a failing status");

	// no reported item means zero kind and id
	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[3]) |-> (m_tdata[33:0] == '0))
		else $error("item fields not cleared without a reported item");

	// a datapath update never runs while the controller can take a word
	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != DP_NONE) |-> !s_tready)
		else $error("datapath update while idle");

endmodule

// ----- sim/queue_stack_exchange_engine_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the queue and stack exchange engine: predicts each result word and checks it.
module queue_stack_exchange_engine_tb;
	import qse_pkg::*;

	localparam int QD = QUEUE_DEPTH_DEF;
	localparam int SD = STACK_DEPTH_DEF;
	localparam int SWAPS = SWAP_COUNT_DEF;
	// Action codes with no meaning; the block must leave its state alone.
	localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		sts_code_t            status;
		logic                 item_valid;
		item_t                item;
		logic [QFILL_W-1:0]   qfill;
		logic [SFILL_W-1:0]   sfill;
	} outcome_t;

	class exchange_board;
		item_t    q_mem[QD];
		int       q_head;
		int       q_cnt;
		item_t    s_mem[SD];
		int       s_cnt;
		outcome_t pending_q[$];
		int       errors;
		int       words_in;
		int       words_out;
		int       removed_seen;
		int       status_seen[8];

		function void push_tail(item_t fresh);
			q_mem[(q_head + q_cnt) % QD] = fresh;
			q_cnt++;
		endfunction

		function item_t pop_front();
			item_t front;
			front = q_mem[q_head];
			q_head = (q_head + 1) % QD;
			q_cnt--;
			return front;
		endfunction

		// Advance the private copy of the queue and stack by one word.
		function void note_word(logic [ACTION_W-1:0] act, item_t fresh);
			outcome_t r;
			item_t    tmp;
			int       qi;
			int       si;
			r.status = STS_OK;
			r.item_valid = 1'b0;
			r.item = '0;
			case (act)
				ACT_APPEND: begin
					if (q_cnt >= QD) r.status = STS_QUEUE_FULL;
					else push_tail(fresh);
				end
				ACT_PLAY: begin
					if (q_cnt == 0) begin
						r.status = STS_QUEUE_EMPTY;
					end else begin
						r.item = pop_front();
						r.item_valid = 1'b1;
						push_tail(fresh);
					end
				end
				ACT_RESERVE: begin
					if (s_cnt >= SD) begin
						r.status = STS_STACK_FULL;
					end else if (q_cnt == 0) begin
						r.status = STS_QUEUE_EMPTY;
					end else begin
						r.item = pop_front();
						r.item_valid = 1'b1;
						s_mem[s_cnt] = r.item;
						s_cnt++;
						push_tail(fresh);
					end
				end
				ACT_USE_TOP: begin
					if (s_cnt == 0) begin
						r.status = STS_STACK_EMPTY;
					end else begin
						s_cnt--;
						r.item = s_mem[s_cnt];
						r.item_valid = 1'b1;
					end
				end
				ACT_SWAP_ONE: begin
					if (q_cnt == 0 || s_cnt == 0) begin
						r.status = STS_TOO_FEW;
					end else begin
						tmp = q_mem[q_head];
						q_mem[q_head] = s_mem[s_cnt-1];
						s_mem[s_cnt-1] = tmp;
					end
				end
				ACT_SWAP_THREE: begin
					if (q_cnt < SWAPS || s_cnt < SWAPS) begin
						r.status = STS_TOO_FEW;
					end else begin
						// mirror: i-th from the queue front pairs with i-th from the stack top
						for (int i = 0; i < SWAPS; i++) begin
							qi = (q_head + i) % QD;
							si = s_cnt - 1 - i;
							tmp = q_mem[qi];
							q_mem[qi] = s_mem[si];
							s_mem[si] = tmp;
						end
					end
				end
				default: ;
			endcase
			r.qfill = QFILL_W'(q_cnt);
			r.sfill = SFILL_W'(s_cnt);
			pending_q.push_back(r);
			words_in++;
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: result %0d %s mismatch: expected %h actual %h",
					$time, words_out, field, want, got);
		endfunction

		function void check_word(outcome_t got);
			outcome_t want;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result: expected none actual %h", $time, got);
				return;
			end
			want = pending_q.pop_front();
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.item_valid !== want.item_valid)
				report("item_valid", 32'(want.item_valid), 32'(got.item_valid));
			if (got.item.kind !== want.item.kind)
				report("item_kind", 32'(want.item.kind), 32'(got.item.kind));
			if (got.item.id !== want.item.id) report("item_id", want.item.id, got.item.id);
			if (got.qfill !== want.qfill)
				report("queue_fill", 32'(want.qfill), 32'(got.qfill));
			if (got.sfill !== want.sfill)
				report("stack_fill", 32'(want.sfill), 32'(got.sfill));
			status_seen[want.status]++;
			if (want.item_valid) removed_seen++;
			words_out++;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [39:0]         s_tdata;
	logic [ACTION_W-1:0] s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [47:0]         m_tdata;
	logic [3:0]          m_tuser;

	exchange_board board;
	int ready_mode = 0;
	int ready_left = 0;
	int ready_tick = 0;

	queue_stack_exchange_engine uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("queue_stack_exchange_engine_tb: errors");
		$finish;
	end

	// Receiver: switch between always ready, mostly ready, mostly stalled and a slow toggle.
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_left <= $urandom_range(20, 200);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ready_tick[2];
		endcase
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.status = sts_code_t'(m_tuser[2:0]);
			got.item_valid = m_tuser[3];
			got.item.kind = m_tdata[1:0];
			got.item.id = m_tdata[33:2];
			got.qfill = m_tdata[37:34];
			got.sfill = m_tdata[40:38];
			board.check_word(got);
		end
	end

	// Present one word and hold it until the block takes it; valid stays high afterwards.
	task automatic send_word(input logic [ACTION_W-1:0] act, input logic [KIND_W-1:0] kind,
			input logic [ID_W-1:0] id);
		item_t fresh;
		fresh.kind = kind;
		fresh.id = id;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'b0, id, kind};
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note_word(act, fresh);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [ACTION_W-1:0] pick_action();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) return ACT_APPEND;
		if (roll < 30) return ACT_PLAY;
		if (roll < 52) return ACT_RESERVE;
		if (roll < 72) return ACT_USE_TOP;
		if (roll < 83) return ACT_SWAP_ONE;
		if (roll < 96) return ACT_SWAP_THREE;
		return (roll[0]) ? ACT_SPARE_7 : ACT_SPARE_6;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int burst;
		int gap;
		int sent;
		board = new;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_APPEND;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every rejection on empty stores, spare codes, extremes, fill to both limits.
		send_word(ACT_USE_TOP, 2'd0, '0);
		send_word(ACT_PLAY, 2'd3, '1);
		send_word(ACT_RESERVE, 2'd1, 32'h1234_5678);
		send_word(ACT_SWAP_ONE, 2'd2, '0);
		send_word(ACT_SWAP_THREE, 2'd3, '1);
		send_word(ACT_SPARE_6, 2'd3, '1);
		send_word(ACT_SPARE_7, 2'd0, '0);
		send_word(ACT_APPEND, 2'd0, '0);
		send_word(ACT_APPEND, 2'd3, '1);
		send_word(ACT_APPEND, 2'd1, 32'hAAAA_AAAA);
		send_word(ACT_SWAP_THREE, 2'd0, '0);
		send_word(ACT_RESERVE, 2'd2, 32'h5555_5555);
		send_word(ACT_SWAP_ONE, 2'd0, '0);
		send_word(ACT_RESERVE, 2'd1, 32'h8000_0001);
		send_word(ACT_RESERVE, 2'd2, 32'h7FFF_FFFE);
		send_word(ACT_SWAP_THREE, 2'd0, '0);
		send_word(ACT_RESERVE, 2'd3, 32'hDEAD_BEEF);
		send_word(ACT_RESERVE, 2'd0, 32'h0F0F_0F0F);
		for (int i = 0; i < 5; i++) send_word(ACT_APPEND, i[1:0], $urandom);
		send_word(ACT_APPEND, 2'd3, '1);
		send_word(ACT_PLAY, 2'd2, 32'hF0F0_F0F0);
		send_word(ACT_USE_TOP, 2'd0, '0);
		drain();

		// Random: bursts with random gaps, two full drains along the way.
		sent = 0;
		while (sent < 950) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			for (int i = 0; i < burst; i++) begin
				send_word(pick_action(), KIND_W'($urandom_range(0, 3)), pick_id());
				sent++;
			end
			if (sent >= 300 && sent - burst < 300 || sent >= 650 && sent - burst < 650) begin
				drain();
			end else if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		drain();
		repeat (20) @(posedge clk);

		$display("summary: %0d words sent, %0d results checked, %0d with a removed item",
			board.words_in, board.words_out, board.removed_seen);
		$display("summary: status ok/qempty/qfull/sfull/sempty/toofew = %0d/%0d/%0d/%0d/%0d/%0d",
			board.status_seen[STS_OK], board.status_seen[STS_QUEUE_EMPTY],
			board.status_seen[STS_QUEUE_FULL], board.status_seen[STS_STACK_FULL],
			board.status_seen[STS_STACK_EMPTY], board.status_seen[STS_TOO_FEW]);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("queue_stack_exchange_engine_tb: clean");
		end else begin
			$display("queue_stack_exchange_engine_tb: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/qse_pkg.sv
design/qse_ctrl.sv
design/qse_dpath.sv
design/queue_stack_exchange_engine.sv
sim/queue_stack_exchange_engine_tb.sv
